/* src/atq_pkg.sv */
// Package for the quoted argument tokeniser.
// Holds the scan mode type, character codes and the result record type.
// No dependencies.
package atq_pkg;

   // Character codes
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;

   // Reset value of the argument limit
   localparam logic [7:0] ARG_LIMIT_RESET = 8'hFF;

   // Field saturation limit for offsets and lengths
   localparam logic [15:0] FIELD_MAX = 16'hFFFF;

   // Scan mode, one-hot
   typedef enum logic [2:0] {
      MODE_SKIP   = 3'b001,
      MODE_PLAIN  = 3'b010,
      MODE_QUOTED = 3'b100
   } scan_mode_type;

   // One result record
   typedef struct packed {
      logic        arg_found;
      logic [7:0]  arg_index;
      logic [15:0] arg_start;
      logic [15:0] arg_length;
      logic [7:0]  arg_total;
      logic        buffer_done;
   } result_type;

endpackage

/* src/atq_scan.sv */
// Input register and tokeniser step: scan mode, offsets and argument count.
// Produces one result record per completed argument or end of buffer.
// Depends on atq_pkg.
module atq_scan #(
   parameter int MAX_BUFFER_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_buffer,
   input  logic [7:0]          arg_limit,
   input  logic                out_full,
   output logic                push,
   output atq_pkg::result_type push_data
);

   localparam int POS_W = $clog2(MAX_BUFFER_BYTES);
   localparam int TOK_W = POS_W + 1;
   localparam int SAT_W = (TOK_W > 16) ? TOK_W : 16;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_BUFFER_BYTES - 1);

   // Input register
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_eob_ff;

   // Scan state
   atq_pkg::scan_mode_type mode_ff, mode_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [TOK_W-1:0]      tok_ff, tok_in;
   logic [7:0]            count_ff, count_in;

   logic                  go;
   logic                  sep, quote, last, ext, found;
   atq_pkg::scan_mode_type mode_mid;
   logic [TOK_W-1:0]      len;
   logic [7:0]            count_inc;
   logic [SAT_W-1:0]      start_x, len_x;

   // Handshake: the step runs when the output buffer has room
   assign go        = in_valid_ff && !out_full;
   assign req_stall = in_valid_ff && !go;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_eob_ff  <= req_end_of_buffer;
      end
   end

   // Character classes and end of buffer
   assign sep   = (in_byte_ff == atq_pkg::CHAR_SPACE) || (in_byte_ff == atq_pkg::CHAR_TAB);
   assign quote = (in_byte_ff == atq_pkg::CHAR_QUOTE);
   assign last  = in_eob_ff || (pos_ff >= LAST_POS);

   // Mode transition on this byte
   always_comb begin
      mode_mid = mode_ff;
      tok_in   = tok_ff;
      found    = 1'b0;
      unique case (mode_ff)
         atq_pkg::MODE_SKIP: begin
            if (!sep && (count_ff < arg_limit)) begin
               if (quote) begin
                  tok_in   = TOK_W'(pos_ff) + TOK_W'(1);
                  mode_mid = atq_pkg::MODE_QUOTED;
               end else begin
                  tok_in   = TOK_W'(pos_ff);
                  mode_mid = atq_pkg::MODE_PLAIN;
               end
            end
         end
         atq_pkg::MODE_PLAIN: begin
            if (sep) begin
               found    = 1'b1;
               mode_mid = atq_pkg::MODE_SKIP;
            end
         end
         atq_pkg::MODE_QUOTED: begin
            if (quote) begin
               found    = 1'b1;
               mode_mid = atq_pkg::MODE_SKIP;
            end
         end
         default: begin
            mode_mid = atq_pkg::MODE_SKIP;
         end
      endcase
   end

   // An argument still open on the last byte ends after it
   assign ext = last && (mode_mid != atq_pkg::MODE_SKIP);
   assign len = TOK_W'(pos_ff) + TOK_W'(ext) - tok_in;

   assign count_inc = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;

   // Next state
   always_comb begin
      mode_in  = ext ? atq_pkg::MODE_SKIP : mode_mid;
      count_in = (found || ext) ? count_inc : count_ff;
      pos_in   = pos_ff + POS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= atq_pkg::MODE_SKIP;
         pos_ff   <= '0;
         tok_ff   <= '0;
         count_ff <= '0;
      end else if (go) begin
         if (last) begin
            mode_ff  <= atq_pkg::MODE_SKIP;
            pos_ff   <= '0;
            tok_ff   <= '0;
            count_ff <= '0;
         end else begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            tok_ff   <= tok_in;
            count_ff <= count_in;
         end
      end
   end

   // Result record, offsets saturated to sixteen bits
   assign start_x = SAT_W'(tok_in);
   assign len_x   = SAT_W'(len);

   always_comb begin
      push_data             = '0;
      push_data.arg_found   = found || ext;
      push_data.arg_total   = count_in;
      push_data.buffer_done = last;
      if (found || ext) begin
         push_data.arg_index  = count_ff;
         push_data.arg_start  = (start_x > SAT_W'(atq_pkg::FIELD_MAX)) ?
                                atq_pkg::FIELD_MAX : start_x[15:0];
         push_data.arg_length = (len_x > SAT_W'(atq_pkg::FIELD_MAX)) ?
                                atq_pkg::FIELD_MAX : len_x[15:0];
      end
   end

   assign push = go && (found || ext || last);

   // A step on the last byte leaves the scan state cleared
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      go && last |=> (pos_ff == '0) && (count_ff == 8'd0) && (mode_ff == atq_pkg::MODE_SKIP))
      else $error("scan state not cleared after end of buffer");

   // Count only grows within a buffer
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      go && !last |=> count_ff >= $past(count_ff))
      else $error("argument count fell within a buffer");

   // A reported argument is included in the running total
   a_index_below_total: assert property (@(posedge clock) disable iff (reset)
      push && push_data.arg_found |-> push_data.arg_index < push_data.arg_total)
      else $error("argument index not below total");

   // No step while the output buffer is full
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      out_full |-> !push)
      else $error("result pushed into full buffer");

endmodule

/* src/atq_rsp_fifo.sv */
// Two-entry result buffer driving the response channel from registers.
// Lets the scan stage keep working while a result waits to be taken.
// Depends on atq_pkg.
module atq_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  atq_pkg::result_type push_data,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output atq_pkg::result_type rsp_data
);

   atq_pkg::result_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Fill count stays within depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result buffer count out of range");

   // Pointers differ by the fill count
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("result buffer pointers inconsistent");

endmodule

/* src/arg_tokenizer_quoted.sv */
// Quoted argument tokeniser: splits a byte stream into argument offsets and lengths.
// A request is held in the input register; its result goes through the result buffer.
// Throughput: one request per cycle while the result buffer has room, else req_stall holds
// the request; the tokeniser step is a single pass of mode logic.
// Requests that produce no result (inside or between arguments) leave the output idle.
// Reset (synchronous, active high) clears scan state, result buffer and sets the limit to 255.
// Depends on atq_pkg, atq_scan and atq_rsp_fifo.
module arg_tokenizer_quoted #(
   parameter int MAX_BUFFER_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_buffer,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_arg_found,
   output logic [7:0]  rsp_arg_index,
   output logic [15:0] rsp_arg_start,
   output logic [15:0] rsp_arg_length,
   output logic [7:0]  rsp_arg_total,
   output logic        rsp_buffer_done,
   // configuration
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0]          arg_limit_ff;
   logic                out_full;
   logic                push;
   atq_pkg::result_type push_data;
   atq_pkg::result_type rsp_data;

   // Argument limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         arg_limit_ff <= atq_pkg::ARG_LIMIT_RESET;
      end else if (csr_wr_en) begin
         arg_limit_ff <= csr_wr_data;
      end
   end

   atq_scan #(
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
   ) u_scan (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .arg_limit         (arg_limit_ff),
      .out_full          (out_full),
      .push              (push),
      .push_data         (push_data)
   );

   atq_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Response fields
   assign rsp_arg_found   = rsp_data.arg_found;
   assign rsp_arg_index   = rsp_data.arg_index;
   assign rsp_arg_start   = rsp_data.arg_start;
   assign rsp_arg_length  = rsp_data.arg_length;
   assign rsp_arg_total   = rsp_data.arg_total;
   assign rsp_buffer_done = rsp_data.buffer_done;

endmodule

/* tb/atq_checker.sv */
// Result checker for the quoted argument tokeniser: predicts the result of every request
// from its own copy of the scan state and compares it field by field with the results seen.
// Depends on atq_pkg for the character codes, scan mode type and result record.
module atq_checker #(
   parameter int MAX_BUFFER_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_buffer,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_arg_found,
   input  logic [7:0]  rsp_arg_index,
   input  logic [15:0] rsp_arg_start,
   input  logic [15:0] rsp_arg_length,
   input  logic [7:0]  rsp_arg_total,
   input  logic        rsp_buffer_done,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int unsigned mismatches,
   output int unsigned pending
);

   // Predicted scan state and the argument limit
   atq_pkg::scan_mode_type mode;
   int unsigned   position;
   int unsigned   arg_begin;
   int unsigned   found_count;
   logic [7:0]    arg_limit;

   // Results still owed by the block, oldest first
   atq_pkg::result_type owed_results[$];

   int unsigned   fail_count = 0;
   int unsigned   results_seen = 0;
   int unsigned   owed_count = 0;

   assign mismatches = fail_count;
   assign pending    = owed_count;

   // Offsets and lengths saturate at sixteen bits
   function automatic logic [15:0] clip16(input int unsigned x);
      return (x > 32'd65535) ? atq_pkg::FIELD_MAX : x[15:0];
   endfunction

   // One byte through the tokeniser; emits is set when the byte gives a result
   function automatic void tokenise_byte(input logic [7:0] b, input logic eob,
                                         output bit emits, output atq_pkg::result_type res);
      bit          last;
      bit          sep;
      bit          found;
      int unsigned len;
      int unsigned idx;
      int unsigned start;
      last  = eob || (position >= MAX_BUFFER_BYTES - 1);
      sep   = (b == atq_pkg::CHAR_SPACE) || (b == atq_pkg::CHAR_TAB);
      found = 1'b0;
      len   = 0;
      idx   = 0;
      start = 0;
      case (mode)
         atq_pkg::MODE_SKIP: begin
            // a new argument starts only below the limit
            if (!sep && found_count < arg_limit) begin
               if (b == atq_pkg::CHAR_QUOTE) begin
                  arg_begin = position + 1;
                  mode      = atq_pkg::MODE_QUOTED;
               end else begin
                  arg_begin = position;
                  mode      = atq_pkg::MODE_PLAIN;
               end
            end
         end
         atq_pkg::MODE_PLAIN: begin
            if (sep) begin
               found = 1'b1;
               len   = position - arg_begin;
               mode  = atq_pkg::MODE_SKIP;
            end
         end
         default: begin
            if (b == atq_pkg::CHAR_QUOTE) begin
               found = 1'b1;
               len   = position - arg_begin;
               mode  = atq_pkg::MODE_SKIP;
            end
         end
      endcase
      // end of buffer closes an open argument
      if (last && mode != atq_pkg::MODE_SKIP) begin
         found = 1'b1;
         len   = position + 1 - arg_begin;
         mode  = atq_pkg::MODE_SKIP;
      end
      if (found) begin
         idx   = found_count;
         start = arg_begin;
         if (found_count < 255) found_count++;
      end
      emits           = found || last;
      res.arg_found   = found;
      res.arg_index   = found ? idx[7:0] : 8'd0;
      res.arg_start   = found ? clip16(start) : 16'd0;
      res.arg_length  = found ? clip16(len) : 16'd0;
      res.arg_total   = found_count[7:0];
      res.buffer_done = last;
      if (last) begin
         mode        = atq_pkg::MODE_SKIP;
         position    = 0;
         arg_begin   = 0;
         found_count = 0;
      end else begin
         position++;
      end
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      fail_count++;
      $display("mismatch on result %0d, %s: got %0d, expected %0d",
               results_seen, what, got, want);
   endtask

   // Watch both channels and the register port at every rising edge
   always @(posedge clock) begin : watch
      bit                  emits;
      atq_pkg::result_type want;
      atq_pkg::result_type res;
      if (reset) begin
         mode        = atq_pkg::MODE_SKIP;
         position    = 0;
         arg_begin   = 0;
         found_count = 0;
         arg_limit   = atq_pkg::ARG_LIMIT_RESET;
         owed_results.delete();
      end else begin
         if (csr_wr_en) arg_limit = csr_wr_data;

         // compare an accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (owed_results.size() == 0) begin
               report_mismatch("result with none expected, arg_index", rsp_arg_index, 0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_arg_found !== want.arg_found)
                  report_mismatch("arg_found", rsp_arg_found, want.arg_found);
               if (rsp_arg_index !== want.arg_index)
                  report_mismatch("arg_index", rsp_arg_index, want.arg_index);
               if (rsp_arg_start !== want.arg_start)
                  report_mismatch("arg_start", rsp_arg_start, want.arg_start);
               if (rsp_arg_length !== want.arg_length)
                  report_mismatch("arg_length", rsp_arg_length, want.arg_length);
               if (rsp_arg_total !== want.arg_total)
                  report_mismatch("arg_total", rsp_arg_total, want.arg_total);
               if (rsp_buffer_done !== want.buffer_done)
                  report_mismatch("buffer_done", rsp_buffer_done, want.buffer_done);
            end
            results_seen++;
         end

         // predict the result of an accepted request
         if (req_valid && !req_stall) begin
            tokenise_byte(req_in_byte, req_end_of_buffer, emits, res);
            if (emits) owed_results.push_back(res);
         end
      end
      owed_count <= owed_results.size();
   end

endmodule

/* tb/tb_arg_tokenizer_quoted.sv */
// Testbench top for the quoted argument tokeniser: drives directed and random byte
// streams, limit changes and output stalls, and gives the verdict.
// Depends on atq_pkg, arg_tokenizer_quoted and atq_checker.
module tb_arg_tokenizer_quoted;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 10;
   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int BUFFER_BYTES = 65536;
   localparam int RANDOM_ITEMS = 670;
   localparam int CALM_ITEMS   = 250;
   localparam int IDLE_PERCENT = 11;
   localparam int DRAIN_CYCLES = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'd0;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_arg_found;
   logic [7:0]  rsp_arg_index;
   logic [15:0] rsp_arg_start;
   logic [15:0] rsp_arg_length;
   logic [7:0]  rsp_arg_total;
   logic        rsp_buffer_done;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;

   int unsigned failures;
   int unsigned pending;
   bit          calm = 1'b0;
   int unsigned sent_count = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   arg_tokenizer_quoted #(
      .MAX_BUFFER_BYTES(BUFFER_BYTES)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_arg_found     (rsp_arg_found),
      .rsp_arg_index     (rsp_arg_index),
      .rsp_arg_start     (rsp_arg_start),
      .rsp_arg_length    (rsp_arg_length),
      .rsp_arg_total     (rsp_arg_total),
      .rsp_buffer_done   (rsp_buffer_done),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   atq_checker #(
      .MAX_BUFFER_BYTES(BUFFER_BYTES)
   ) check_unit (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_arg_found     (rsp_arg_found),
      .rsp_arg_index     (rsp_arg_index),
      .rsp_arg_start     (rsp_arg_start),
      .rsp_arg_length    (rsp_arg_length),
      .rsp_arg_total     (rsp_arg_total),
      .rsp_buffer_done   (rsp_buffer_done),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatches        (failures),
      .pending           (pending)
   );

   // Random stall on the result side, off during the calm stretch
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Run limit
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("Regression FAIL");
      $finish;
   end

   // One request, with random idle cycles first; returns at the falling edge after acceptance
   task automatic send_request(input logic [7:0] b, input logic last);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_buffer <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sent_count++;
   endtask

   // Stop sending and wait until every owed result is in and the pipeline is empty
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      drain_pipeline();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_text(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) send_request(s[i], close && (i == s.len() - 1));
   endtask

   // Mostly text with separators and quotes, some arbitrary bytes
   function automatic logic [7:0] random_text_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 14) return atq_pkg::CHAR_SPACE;
      if (r < 22) return atq_pkg::CHAR_TAB;
      if (r < 32) return atq_pkg::CHAR_QUOTE;
      if (r < 90) return 8'($urandom_range(8'h61, 8'h7A));
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_limit();
      case ($urandom_range(5))
         0:       return 8'd1;
         1:       return 8'd255;
         2:       return 8'd0;
         3:       return 8'd2;
         4:       return 8'd3;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // A random buffer; a few bytes end it early or are preceded by a limit change
   task automatic send_random_buffer(input int unsigned len);
      logic last;
      for (int unsigned i = 0; i < len; i++) begin
         if (i != 0 && $urandom_range(99) < 2) write_limit(pick_limit());
         last = (i == len - 1) || ($urandom_range(99) < 2);
         send_request(random_text_byte(), last);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: opening quote as the last byte
      send_text("\"", 1'b1);
      // closing quote as the last byte
      send_text("\"xy\"", 1'b1);
      // inner quote, quoted separators, argument straight after a closing quote,
      // unclosed argument at the end
      send_text("a\"b \"c d\"e\tf", 1'b1);
      // separators only
      send_text(" \t ", 1'b1);
      // byte extremes
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b1);
      // limit lowered to the count with an argument open
      send_text("a b", 1'b0);
      write_limit(8'd1);
      send_text(" c", 1'b1);
      write_limit(8'd255);

      // random buffers, the first stretch without idling
      calm = 1'b1;
      sent_count = 0;
      while (sent_count < RANDOM_ITEMS) begin
         if (sent_count >= CALM_ITEMS) calm = 1'b0;
         if ($urandom_range(99) < 15) write_limit(pick_limit());
         send_random_buffer(($urandom_range(99) < 85) ? $urandom_range(1, 16)
                                                      : $urandom_range(17, 60));
      end

      drain_pipeline();
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
